>>> sv/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types of the fixed-frame COBS receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // Default decoded payload length of one frame.
    localparam int CFR_PAYLOAD_LEN = 12;

    // Frame delimiter byte.
    localparam logic [7:0] CFR_DELIM = 8'h00;

    // Block code that carries no implied trailing zero.
    localparam logic [7:0] CFR_CODE_MAX = 8'hFF;

    // One decoded result as it leaves the decoder.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_last;
        logic       decode_error;
    } t_cfr_token;

endpackage

>>> sv/cfr_if.sv
// ----------------------------------------------------------------------------
// cfr_if
// Valid/ready channels of the receiver: received bytes in, payload bytes out.
// ----------------------------------------------------------------------------
interface cfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_pl_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       is_last;
    logic       decode_error;

    modport source (output valid, output payload_byte, output is_last,
                    output decode_error, input ready);
    modport sink   (input valid, input payload_byte, input is_last,
                    input decode_error, output ready);
endinterface

>>> sv/cfr_frame_mem.sv
// ----------------------------------------------------------------------------
// cfr_frame_mem
// Frame buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfr_frame_mem #(
    parameter int DEPTH = 14,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/cfr_decoder.sv
// ----------------------------------------------------------------------------
// cfr_decoder
// Byte intake into the frame buffer and sequential COBS decode of a frame.
// ----------------------------------------------------------------------------
module cfr_decoder
    import cfr_pkg::*;
#(
    parameter int PAYLOAD_LEN = CFR_PAYLOAD_LEN,
    parameter int DEPTH       = CFR_PAYLOAD_LEN + 2,
    parameter int AW          = $clog2(CFR_PAYLOAD_LEN + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfr_rx_if.sink        i_rx,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    output logic          o_tok_valid,
    output t_cfr_token    o_tok,
    input  logic          i_tok_ready
);

    localparam int ENC_LEN = PAYLOAD_LEN + 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int OW      = $clog2(PAYLOAD_LEN + 1);

    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ENC  = CW'(ENC_LEN);
    localparam logic [AW-1:0] IDX_END  = AW'(ENC_LEN);
    localparam logic [AW-1:0] IDX_LAST = AW'(ENC_LEN - 1);
    localparam logic [OW-1:0] O_LAST   = OW'(PAYLOAD_LEN - 1);
    localparam logic [OW-1:0] O_FULL   = OW'(PAYLOAD_LEN);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [7:0]    r_rem, n_rem;
    logic          r_code_ff, n_code_ff;
    logic          r_zero_pend, n_zero_pend;
    logic [OW-1:0] r_o, n_o;
    logic          r_err, n_err;
    logic [7:0]    r_last_byte, n_last_byte;

    logic          tok_gen;
    logic [7:0]    tok_val;

    assign i_rx.ready = (r_state == ST_IDLE);
    assign o_wr_addr  = r_count[AW-1:0];
    assign o_wr_data  = i_rx.rx_byte;
    // Read address runs one step ahead so the next stored byte is ready on use.
    assign o_rd_addr  = (r_state == ST_IDLE) ? '0 : n_idx;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_code_ff   = r_code_ff;
        n_zero_pend = r_zero_pend;
        n_o         = r_o;
        n_err       = r_err;
        n_last_byte = r_last_byte;
        o_wr_en     = 1'b0;
        o_tok_valid = 1'b0;
        o_tok       = '0;
        tok_gen     = 1'b0;
        tok_val     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_rx.valid) begin
                    if (i_rx.rx_byte != CFR_DELIM) begin
                        if (r_count < CNT_FULL) begin
                            o_wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_count != '0) begin
                        n_count = '0;
                        if (r_count == CNT_ENC) begin
                            n_state     = ST_SCAN;
                            n_idx       = '0;
                            n_rem       = '0;
                            n_code_ff   = 1'b0;
                            n_zero_pend = 1'b0;
                            n_o         = '0;
                            n_err       = 1'b0;
                            n_last_byte = '0;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (i_tok_ready) begin
                    if (r_zero_pend) begin
                        tok_gen     = 1'b1;
                        n_zero_pend = 1'b0;
                    end else if (r_idx == IDX_END) begin
                        // A block still open means the code ran past the frame.
                        n_err   = r_err | (r_rem != '0) | (r_o != O_FULL);
                        n_state = ST_PAD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        if (r_rem == '0) begin
                            n_code_ff = (i_rd_data == CFR_CODE_MAX);
                            n_rem     = i_rd_data - 1'b1;
                            if (i_rd_data == 8'h01) begin
                                n_zero_pend = (r_idx != IDX_LAST);
                            end
                        end else begin
                            tok_gen = 1'b1;
                            tok_val = i_rd_data;
                            n_rem   = r_rem - 1'b1;
                            if (r_rem == 8'h01) begin
                                n_zero_pend = !r_code_ff && (r_idx != IDX_LAST);
                            end
                        end
                    end
                end
            end
            ST_PAD: begin
                if (i_tok_ready) begin
                    o_tok_valid = 1'b1;
                    if (r_o < O_LAST) begin
                        n_o = r_o + 1'b1;
                    end else begin
                        o_tok.payload_byte = r_last_byte;
                        o_tok.is_last      = 1'b1;
                        o_tok.decode_error = r_err;
                        n_state            = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // The final byte is held back until the whole chain has been checked.
        if (tok_gen) begin
            if (r_o < O_LAST) begin
                o_tok_valid        = 1'b1;
                o_tok.payload_byte = tok_val;
            end else if (r_o == O_LAST) begin
                n_last_byte = tok_val;
            end else begin
                n_err = 1'b1;
            end
            if (r_o != O_FULL) begin
                n_o = r_o + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_zero_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_zero_pend <= n_zero_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_rem       <= n_rem;
        r_code_ff   <= n_code_ff;
        r_o         <= n_o;
        r_err       <= n_err;
        r_last_byte <= n_last_byte;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("frame byte count beyond buffer depth");

    a_decode_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && n_state == ST_SCAN) |-> (r_count == CNT_ENC))
        else $error("decode started on a frame of wrong length");

    a_tok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_valid |-> (r_state == ST_SCAN || r_state == ST_PAD))
        else $error("result produced outside decode");

    a_no_intake_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> $stable(r_count) || (r_state == ST_IDLE))
        else $error("byte count changed during decode");

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD) |-> (r_o <= O_FULL))
        else $error("payload count overran in padding");
`endif

endmodule

>>> sv/cobs_fixed_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// cobs_fixed_frame_receiver_top
// Fixed-frame COBS receiver: buffers a frame, decodes it, streams the payload.
//
//   Channel  Dir  Payload                               Transaction
//   i_rx     in   rx_byte[7:0]                          valid && ready
//   o_pl     out  payload_byte[7:0], is_last, decode_error  valid && ready
//
// Received bytes are taken while the decoder is idle. After a delimiter that
// closes a frame of PAYLOAD_LEN+1 bytes, the decoder walks the frame buffer
// through its single read port, one stored byte or one implied zero per cycle
// unless back-pressure on o_pl stalls it. i_rx ready stays low until the last
// payload byte, padded bytes included, has been passed to the output register.
// Reset is synchronous and active low; the buffer itself is not cleared.
// Back-pressure on o_pl stalls the decode walk; the output register lets a
// finished last byte wait while new bytes are taken.
// ----------------------------------------------------------------------------
module cobs_fixed_frame_receiver_top
    import cfr_pkg::*;
#(
    parameter int PAYLOAD_LEN = CFR_PAYLOAD_LEN
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cfr_rx_if.sink   i_rx,
    cfr_pl_if.source o_pl
);

    localparam int DEPTH = PAYLOAD_LEN + 2;
    localparam int AW    = $clog2(DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          tok_valid;
    t_cfr_token    tok;
    logic          tok_ready;

    logic          r_out_valid;
    t_cfr_token    r_out;

    cfr_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cfr_decoder #(
        .PAYLOAD_LEN (PAYLOAD_LEN),
        .DEPTH       (DEPTH),
        .AW          (AW)
    ) u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_ready (tok_ready)
    );

    assign tok_ready = !r_out_valid || o_pl.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tok_ready) begin
            r_out_valid <= tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_ready && tok_valid) begin
            r_out <= tok;
        end
    end

    assign o_pl.valid        = r_out_valid;
    assign o_pl.payload_byte = r_out.payload_byte;
    assign o_pl.is_last      = r_out.is_last;
    assign o_pl.decode_error = r_out.decode_error;

endmodule
